// ----- rtl/allocation_bounds_checker_core_macros.svh -----
// Assertion macros for the allocation bounds checker core.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef ALLOCATION_BOUNDS_CHECKER_CORE_MACROS_SVH
`define ALLOCATION_BOUNDS_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bounds checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ABC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bounds checker assertion failed");

`endif

// ----- rtl/abc_pkg.sv -----
// Shared types and codes for the allocation bounds checker core.
// No dependencies; imported by abc_cell and the top level.
package abc_pkg;

	// Default number of table entries.
	localparam int DEPTH_DEFAULT = 32;

	// Opcodes.
	localparam logic [2:0] OP_REGISTER = 3'd0;
	localparam logic [2:0] OP_RELEASE  = 3'd1;
	localparam logic [2:0] OP_CHECK    = 3'd2;
	localparam logic [2:0] OP_RANGE    = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// Lookup packet that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic        valid;
		logic [2:0]  op;
		logic [63:0] address;
		logic        found;
		logic        shift;
		logic [63:0] rbase;
		logic [63:0] rsize;
		logic [63:0] offset;
	} pkt_t;

	// Broadcast write of a new region; the cell at the fill index takes it.
	typedef struct packed {
		logic        en;
		logic [63:0] base;
		logic [63:0] size;
	} wr_t;

endpackage

// ----- rtl/abc_cell.sv -----
// One table entry of the bounds checker chain and its lookup stage.
// Depends on abc_pkg for the packet and write types.
module abc_cell
	import abc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int INDEX = 0,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] count_in,
	input  wr_t           wr,
	input  pkt_t          pkt_in,
	input  logic [63:0]   next_base,
	input  logic [63:0]   next_size,
	output pkt_t          pkt_out,
	output logic [63:0]   base,
	output logic [63:0]   size
);

	logic [63:0] base_q;
	logic [63:0] size_q;
	pkt_t        pkt_q;
	pkt_t        pkt_d;
	logic        occupied;
	logic [63:0] diff;
	logic        contains;
	logic        hit;
	logic        is_check;

	assign occupied = CW'(INDEX) < count_in;
	assign diff     = pkt_in.address - base_q;
	assign contains = (pkt_in.address >= base_q) && (diff < size_q);
	assign is_check = (pkt_in.op == OP_CHECK) || (pkt_in.op == OP_RANGE);

	// A cell matches only if no earlier cell has.
	always_comb begin
		hit = 1'b0;
		if (occupied && !pkt_in.found) begin
			if (is_check) begin
				hit = contains;
			end else if (pkt_in.op == OP_RELEASE) begin
				hit = (base_q == pkt_in.address);
			end
		end
	end

	// Stage logic: a hit captures the entry and, for a release, starts the shift.
	always_comb begin
		pkt_d = pkt_in;
		if (hit) begin
			pkt_d.found  = 1'b1;
			pkt_d.rbase  = base_q;
			pkt_d.rsize  = size_q;
			pkt_d.offset = diff;
			pkt_d.shift  = (pkt_in.op == OP_RELEASE);
		end
	end

	// Packet register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q <= pkt_d;
		end
	end

	// Entry storage: a new region lands at the fill index, and once a
	// shifting release beat has passed, the entry takes its neighbor's.
	always_ff @(posedge clk) begin
		if (wr.en && (count_in == CW'(INDEX))) begin
			base_q <= wr.base;
			size_q <= wr.size;
		end else if (pkt_q.valid && pkt_q.shift) begin
			base_q <= next_base;
			size_q <= next_size;
		end
	end

	assign pkt_out = pkt_q;
	assign base    = base_q;
	assign size    = size_q;

endmodule

// ----- rtl/allocation_bounds_checker_core.sv -----
// Allocation bounds checker: a table of up to TABLE_DEPTH memory regions held in a
// chain of cells, one entry per cell, kept in insertion order with no gaps. One
// operation runs at a time. A lookup (release, check pointer, check range) walks
// the whole chain one cell per cycle and then finishes; register passes through
// the states S_MUL_HI and S_MUL_AD, which build the 64x32 size product from two
// 32x32 partial products, and then finishes; clear all, unknown opcodes and a
// register into a full table go straight to the finishing state. The result
// appears in the same cycle in which the next beat can be accepted. A new beat
// is accepted while the previous result still waits on the output register; a
// result that finds the output register still held stretches its operation until
// that beat is taken.
`include "allocation_bounds_checker_core_macros.svh"

module allocation_bounds_checker_core
	import abc_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [63:0] address,
	input  logic [63:0] length,
	input  logic [31:0] count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] region_base,
	output logic [63:0] region_size,
	output logic [5:0]  entry_count
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL_HI = 3'd1;
	localparam logic [2:0] S_MUL_AD = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] newcount_q;
	logic [63:0]   len_q;
	logic [63:0]   addr_q;
	logic [31:0]   cnt_q;
	logic [63:0]   plo_q;
	logic [31:0]   phi_q;
	logic [63:0]   plo_d;
	logic [31:0]   phi_d;
	logic [63:0]   size_sum;
	logic [1:0]    res_status_q;
	logic [63:0]   res_base_q;
	logic [63:0]   res_size_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [63:0]   out_base_q;
	logic [63:0]   out_size_q;
	logic [5:0]    out_count_q;
	pkt_t          pkt_inj_q;
	wr_t           wr;
	logic          accept;
	logic          fin_go;
	pkt_t          end_pkt;
	logic [63:0]   remain;

	pkt_t        pkt_w  [TABLE_DEPTH+1];
	logic [63:0] base_w [TABLE_DEPTH];
	logic [63:0] size_w [TABLE_DEPTH];
	logic [63:0] nbase_w[TABLE_DEPTH];
	logic [63:0] nsize_w[TABLE_DEPTH];

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// Size product from two 32x32 partial products.
	assign plo_d    = 64'(length[31:0]) * 64'(count);
	assign phi_d    = len_q[63:32] * cnt_q;
	assign size_sum = plo_q + {phi_q, 32'd0};

	// Broadcast write into the cell at the fill index.
	assign wr.en   = (state_q == S_MUL_AD);
	assign wr.base = addr_q;
	assign wr.size = size_sum;

	// Cell chain.
	assign pkt_w[0] = pkt_inj_q;
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign nbase_w[i] = base_w[i];
			assign nsize_w[i] = size_w[i];
		end else begin : g_mid
			assign nbase_w[i] = base_w[i+1];
			assign nsize_w[i] = size_w[i+1];
		end
		abc_cell #(
			.DEPTH(TABLE_DEPTH),
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count_in (count_q),
			.wr       (wr),
			.pkt_in   (pkt_w[i]),
			.next_base(nbase_w[i]),
			.next_size(nsize_w[i]),
			.pkt_out  (pkt_w[i+1]),
			.base     (base_w[i]),
			.size     (size_w[i])
		);
	end

	assign end_pkt = pkt_w[TABLE_DEPTH];
	assign remain  = end_pkt.rsize - end_pkt.offset;

	// Sequencer, count and the lookup packet injected into the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			pkt_inj_q <= '0;
		end else begin
			pkt_inj_q.valid <= accept && (opcode inside {OP_RELEASE, OP_CHECK, OP_RANGE});
			case (state_q)
				S_IDLE: begin
					pkt_inj_q.op      <= opcode;
					pkt_inj_q.address <= address;
					pkt_inj_q.found   <= 1'b0;
					pkt_inj_q.shift   <= 1'b0;
					pkt_inj_q.rbase   <= '0;
					pkt_inj_q.rsize   <= '0;
					pkt_inj_q.offset  <= '0;
					if (accept) begin
						case (opcode)
							OP_REGISTER: begin
								if (count_q == CW'(TABLE_DEPTH)) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_MUL_HI;
								end
							end
							OP_RELEASE, OP_CHECK, OP_RANGE: begin
								state_q <= S_WALK;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_MUL_HI: state_q <= S_MUL_AD;
				S_MUL_AD: state_q <= S_FIN;
				S_WALK: begin
					if (end_pkt.valid) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						count_q <= newcount_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operand, product and pending result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q     <= address;
				len_q      <= length;
				cnt_q      <= count;
				plo_q      <= plo_d;
				res_base_q <= '0;
				res_size_q <= '0;
				res_status_q <= (opcode == OP_REGISTER && count_q == CW'(TABLE_DEPTH)) ?
					ST_FULL : ST_OK;
				newcount_q <= (opcode == OP_CLEAR) ? '0 : count_q;
			end
			S_MUL_HI: begin
				phi_q <= phi_d;
			end
			S_MUL_AD: begin
				res_base_q <= addr_q;
				res_size_q <= size_sum;
				newcount_q <= count_q + CW'(1);
			end
			S_WALK: begin
				if (end_pkt.valid) begin
					res_base_q <= end_pkt.rbase;
					res_size_q <= end_pkt.rsize;
					if (end_pkt.op == OP_RELEASE) begin
						res_status_q <= ST_OK;
						if (end_pkt.found) begin
							newcount_q <= count_q - CW'(1);
						end
					end else if (!end_pkt.found) begin
						res_status_q <= ST_INVALID;
					end else if (end_pkt.op == OP_RANGE && len_q > remain) begin
						res_status_q <= ST_RANGE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_status_q <= res_status_q;
			out_base_q   <= res_base_q;
			out_size_q   <= res_size_q;
			out_count_q  <= 6'(newcount_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign region_base = out_base_q;
	assign region_size = out_size_q;
	assign entry_count = out_count_q;

	// Checks on the sequencer and the table count.
	`ABC_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE)
	`ABC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH))
	`ABC_ASSERT_NEXT(a_walk_done, (state_q == S_WALK) && end_pkt.valid, state_q == S_FIN)
	`ABC_ASSERT_NOW(a_full_count, out_valid_q && (out_status_q == ST_FULL),
		count_q == CW'(TABLE_DEPTH))

endmodule
